@@ hw/rtl/packet_framer_checksum8_unit_assert.svh @@
// Assertion macros used by the port checker file.
`ifndef PACKET_FRAMER_CHECKSUM8_UNIT_ASSERT_SVH
`define PACKET_FRAMER_CHECKSUM8_UNIT_ASSERT_SVH

// Same-cycle implication under reset.
`define PFC8_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication under reset.
`define PFC8_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/pfc8_pkg.sv @@
package pfc8_pkg;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_DATA  = 1'b1;

	localparam int unsigned MAX_RESULTS = 3;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_checksum;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [7:0] running_sum;
		logic [7:0] bytes_left;
		logic       frame_open;
	} frame_state_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r2;
		result_t    r1;
		result_t    r0;
	} step_t;

	function automatic logic [7:0] checksum_of(input logic [7:0] sum);
		return 8'(8'd0 - sum);
	endfunction

endpackage

@@ hw/rtl/pfc8_frame_calc.sv @@
module pfc8_frame_calc (
	input  logic                  kind,
	input  logic [7:0]            header,
	input  logic [7:0]            length,
	input  logic [7:0]            data_byte,
	input  pfc8_pkg::frame_state_t cur,
	output pfc8_pkg::frame_state_t nxt,
	output pfc8_pkg::step_t       step
);

	logic [7:0] start_sum;
	logic [7:0] data_sum;
	logic [7:0] left_dec;

	assign start_sum = 8'(header + length);
	assign data_sum  = 8'(cur.running_sum + data_byte);
	assign left_dec  = 8'(cur.bytes_left - 8'd1);

	always_comb begin
		nxt  = cur;
		step = '0;
		case (kind)
			pfc8_pkg::KIND_START: begin
				nxt.running_sum = start_sum;
				nxt.bytes_left  = length;
				step.r0         = '{out_byte: header, is_checksum: 1'b0, last: 1'b0};
				if (length == 8'd0) begin
					nxt.frame_open = 1'b0;
					step.count     = 2'd3;
					step.r1        = '{out_byte: length, is_checksum: 1'b0, last: 1'b0};
					step.r2        = '{out_byte: pfc8_pkg::checksum_of(start_sum),
						is_checksum: 1'b1, last: 1'b1};
				end else begin
					nxt.frame_open = 1'b1;
					step.count     = 2'd2;
					step.r1        = '{out_byte: length, is_checksum: 1'b0, last: 1'b1};
				end
			end
			pfc8_pkg::KIND_DATA: begin
				if (cur.frame_open) begin
					nxt.running_sum = data_sum;
					nxt.bytes_left  = left_dec;
					if (left_dec == 8'd0) begin
						nxt.frame_open = 1'b0;
						step.count     = 2'd2;
						step.r0        = '{out_byte: data_byte, is_checksum: 1'b0,
							last: 1'b0};
						step.r1        = '{out_byte: pfc8_pkg::checksum_of(data_sum),
							is_checksum: 1'b1, last: 1'b1};
					end else begin
						step.count = 2'd1;
						step.r0    = '{out_byte: data_byte, is_checksum: 1'b0, last: 1'b1};
					end
				end
			end
			default: begin
				nxt  = cur;
				step = '0;
			end
		endcase
	end

endmodule

@@ hw/rtl/packet_framer_checksum8_unit.sv @@
// Length-prefixed frame builder with an 8-bit two's complement checksum.
// A start item (kind 0) emits the header byte, then the length byte, and for a
// zero length also the checksum; each payload item (kind 1) of an open frame
// is passed through, followed by the checksum after the last byte. Payload
// items with no open frame are dropped. Results leave from a three-entry
// output queue, one byte per cycle while out_ready is high; a new item
// is taken when the queue holds at most one entry that is being transferred.
// Payload items therefore stream at one per cycle while out_ready is high,
// a start item yields two or three output bytes, a closing payload byte two.
// Results appear in the cycle after the input transfer.
module packet_framer_checksum8_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [7:0] header,
	input  logic [7:0] length,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       is_checksum,
	output logic       last
);

	pfc8_pkg::frame_state_t state_q;
	pfc8_pkg::frame_state_t state_nxt;
	pfc8_pkg::step_t        step;
	pfc8_pkg::result_t      res_q [pfc8_pkg::MAX_RESULTS];
	logic [1:0]             cnt_q;
	logic                   in_xfer;
	logic                   out_xfer;

	pfc8_frame_calc u_calc (
		.kind      (kind),
		.header    (header),
		.length    (length),
		.data_byte (data_byte),
		.cur       (state_q),
		.nxt       (state_nxt),
		.step      (step)
	);

	assign out_valid = (cnt_q != 2'd0);
	assign out_xfer  = out_valid && out_ready;
	assign in_ready  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready);
	assign in_xfer   = in_valid && in_ready;

	assign out_byte    = res_q[0].out_byte;
	assign is_checksum = res_q[0].is_checksum;
	assign last        = res_q[0].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			cnt_q   <= 2'd0;
		end else if (in_xfer) begin
			state_q <= state_nxt;
			cnt_q   <= step.count;
		end else if (out_xfer) begin
			cnt_q <= 2'(cnt_q - 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_q[0] <= step.r0;
			res_q[1] <= step.r1;
			res_q[2] <= step.r2;
		end else if (out_xfer) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

endmodule

@@ hw/rtl/pfc8_port_checker.sv @@
`include "packet_framer_checksum8_unit_assert.svh"

module pfc8_port_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       kind,
	input logic [7:0] header,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       is_checksum,
	input logic       last
);

	`PFC8_ASSERT_IMPL(a_chk_is_last, clk, arst_n, out_valid && is_checksum, last)
	`PFC8_ASSERT_IMPL(a_take_when_draining, clk, arst_n, in_ready, !out_valid || out_ready)
	`PFC8_ASSERT_NEXT(a_header_first, clk, arst_n,
		in_valid && in_ready && (kind == pfc8_pkg::KIND_START),
		out_valid && (out_byte == $past(header)) && !is_checksum && !last)
	`PFC8_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_byte) && $stable(last))

endmodule

bind packet_framer_checksum8_unit pfc8_port_checker u_pfc8_port_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.kind        (kind),
	.header      (header),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.out_byte    (out_byte),
	.is_checksum (is_checksum),
	.last        (last)
);
